/* design/assert_macros.svh */
// Assertion macros shared by the RPN calculator RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* design/rpn_pkg.sv */
// Package for the RPN calculator: opcodes, command and status structs.
// Used by the controller, datapath and top level.
package rpn_pkg;
    localparam logic [3:0] FN_PUSH  = 4'd0;
    localparam logic [3:0] FN_ADD   = 4'd1;
    localparam logic [3:0] FN_SUB   = 4'd2;
    localparam logic [3:0] FN_MUL   = 4'd3;
    localparam logic [3:0] FN_DIV   = 4'd4;
    localparam logic [3:0] FN_MOD   = 4'd5;
    localparam logic [3:0] FN_PRINT = 4'd6;
    localparam logic [3:0] FN_STORE = 4'd7;
    localparam logic [3:0] FN_LOAD  = 4'd8;
    localparam logic [3:0] FN_SWAP  = 4'd9;
    localparam logic [3:0] FN_PEEK  = 4'd10;
    localparam logic [3:0] FN_CLEAR = 4'd11;
    localparam logic [3:0] FN_DUP   = 4'd12;

    localparam int NUM_VARS = 26;

    // Datapath micro-operations issued by the controller.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1; // latch token
    localparam logic [2:0] OP_POPB  = 3'd2; // read top into b
    localparam logic [2:0] OP_POPA  = 3'd3; // read top into a
    localparam logic [2:0] OP_EXEC  = 3'd4; // compute / start divider
    localparam logic [2:0] OP_DIVST = 3'd5; // one divider step
    localparam logic [2:0] OP_WB    = 3'd6; // write results, pushes
    localparam logic [2:0] OP_PUSH2 = 3'd7; // second push of swap/dup

    typedef struct packed {
        logic [2:0] op;
    } rpn_cmd_t;

    typedef struct packed {
        logic div_done;
        logic bzero;
        logic [3:0] func;
    } rpn_stat_t;
endpackage

/* design/rpn_datapath.sv */
// Datapath of the RPN calculator: stack memory, variables, ALU, divider.
// Depends on rpn_pkg and assert_macros.svh.
module rpn_datapath #(
    parameter int STACK_DEPTH = 128,
    parameter int SPW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rpn_pkg::rpn_cmd_t cmd,
    output rpn_pkg::rpn_stat_t stat,
    input  logic [3:0]       in_func,
    input  logic [31:0]      in_num,
    input  logic [4:0]       in_idx,
    output logic [31:0]      res_value,
    output logic             res_valid,
    output logic             res_under,
    output logic             res_over,
    output logic             res_dz
);
    import rpn_pkg::*;
    `include "assert_macros.svh"

    localparam logic [SPW-1:0] DEPTH_C = SPW'(STACK_DEPTH);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] vars_reg [NUM_VARS];
    logic [SPW-1:0] sp_reg, sp_next;
    logic [3:0]  func_reg;
    logic [31:0] num_reg;
    logic [4:0]  idx_reg;
    logic signed [31:0] a_reg, b_reg, r_reg;
    logic [31:0] val_reg;
    logic [31:0] top_reg;
    logic valid_reg, under_reg, over_reg, dz_reg;
    // Divider: restoring, 1 quotient bit per step, 48-bit dividend.
    // Div runs 48 steps on |a| * 65536; mod runs 16 steps on the integer parts.
    logic [47:0] dq_reg;
    logic [32:0] drem_reg;
    logic [31:0] dden_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;

    logic [SPW-1:0] rd_ptr;
    logic signed [63:0] prod;
    logic signed [32:0] sum_w, dif_w;
    logic signed [47:0] prod_sh;
    logic [32:0] trial;
    logic signed [15:0] ia16, ib16;
    logic [15:0] ia_mag, ib_mag;
    logic [31:0] rem_q;
    logic        push_we;

    // The top entry is read through a register, addressed by the next pointer.
    assign rd_ptr = sp_next - SPW'(1);

    // Integer parts truncated toward zero.
    function automatic logic signed [15:0] ipart(input logic signed [31:0] v);
        logic [31:0] m;
        begin
            m = v[31] ? (~v + 32'd1) : v;
            ipart = v[31] ? -$signed(m[31:16]) : $signed(m[31:16]);
        end
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        begin
            if (v > 48'sd2147483647) sat48 = 32'sh7fffffff;
            else if (v < -48'sd2147483648) sat48 = 32'sh80000000;
            else sat48 = v[31:0];
        end
    endfunction

    assign sum_w = {a_reg[31], a_reg} + {b_reg[31], b_reg};
    assign dif_w = {a_reg[31], a_reg} - {b_reg[31], b_reg};
    assign prod  = a_reg * b_reg;
    assign prod_sh = prod[63:16];
    assign ia16 = ipart(a_reg);
    assign ib16 = ipart(b_reg);
    assign ia_mag = ia16[15] ? (~$unsigned(ia16) + 16'd1) : $unsigned(ia16);
    assign ib_mag = ib16[15] ? (~$unsigned(ib16) + 16'd1) : $unsigned(ib16);
    assign rem_q = {drem_reg[15:0], 16'h0000};
    assign trial = {drem_reg[31:0], dq_reg[47]} - {1'b0, dden_reg};

    assign stat.func = func_reg;
    assign stat.bzero = (func_reg == FN_MOD) ? (ib16 == 16'sd0) : (b_reg == 32'sd0);
    assign stat.div_done = (dcnt_reg == 6'd0);

    // Stack pointer and flags update.
    always_comb
    begin
        sp_next = sp_reg;
        case (cmd.op)
            OP_POPB, OP_POPA:
            begin
                if (sp_reg != '0) sp_next = sp_reg - SPW'(1);
            end
            OP_WB:
            begin
                if (func_reg == FN_CLEAR) sp_next = '0;
                else if ((func_reg == FN_PUSH || func_reg == FN_ADD || func_reg == FN_SUB ||
                          func_reg == FN_MUL || func_reg == FN_DIV || func_reg == FN_MOD ||
                          func_reg == FN_LOAD || func_reg == FN_SWAP || func_reg == FN_DUP)
                         && !dz_reg && sp_reg < DEPTH_C)
                    sp_next = sp_reg + SPW'(1);
            end
            OP_PUSH2:
            begin
                if (sp_reg < DEPTH_C) sp_next = sp_reg + SPW'(1);
            end
            default: sp_next = sp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            for (int i = 0; i < NUM_VARS; i++) vars_reg[i] <= '0;
            under_reg <= 1'b0;
            over_reg <= 1'b0;
            dz_reg <= 1'b0;
            valid_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
            case (cmd.op)
                OP_START:
                begin
                    under_reg <= 1'b0;
                    over_reg <= 1'b0;
                    dz_reg <= 1'b0;
                    valid_reg <= (in_func == FN_PRINT) || (in_func == FN_PEEK);
                    dcnt_reg <= '0;
                end
                OP_POPB, OP_POPA:
                begin
                    if (sp_reg == '0) under_reg <= 1'b1;
                end
                OP_EXEC:
                begin
                    if (func_reg == FN_PEEK && sp_reg == '0) under_reg <= 1'b1;
                    if ((func_reg == FN_DIV || func_reg == FN_MOD) && stat.bzero)
                        dz_reg <= 1'b1;
                    if (func_reg == FN_DIV && !stat.bzero) dcnt_reg <= 6'd48;
                    else if (func_reg == FN_MOD && !stat.bzero) dcnt_reg <= 6'd16;
                    if (func_reg == FN_STORE && idx_reg < 5'(NUM_VARS))
                        vars_reg[idx_reg] <= a_reg;
                end
                OP_DIVST: dcnt_reg <= dcnt_reg - 6'd1;
                OP_WB:
                begin
                    if (func_reg != FN_CLEAR && func_reg != FN_PRINT && func_reg != FN_PEEK &&
                        func_reg != FN_STORE && func_reg <= FN_DUP && !dz_reg &&
                        sp_reg >= DEPTH_C)
                        over_reg <= 1'b1;
                end
                OP_PUSH2:
                begin
                    if (sp_reg >= DEPTH_C) over_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers and divider.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                func_reg <= in_func;
                num_reg <= in_num;
                idx_reg <= in_idx;
                a_reg <= '0;
                b_reg <= '0;
                val_reg <= '0;
            end
            OP_POPB: b_reg <= (sp_reg == '0) ? 32'sd0 : $signed(top_reg);
            OP_POPA: a_reg <= (sp_reg == '0) ? 32'sd0 : $signed(top_reg);
            OP_EXEC:
            begin
                case (func_reg)
                    FN_PUSH:  r_reg <= $signed(num_reg);
                    FN_ADD:   r_reg <= sat48(48'(sum_w));
                    FN_SUB:   r_reg <= sat48(48'(dif_w));
                    FN_MUL:   r_reg <= sat48(prod_sh);
                    FN_LOAD:  r_reg <= (idx_reg < 5'(NUM_VARS)) ? vars_reg[idx_reg] : 32'sd0;
                    FN_SWAP:  r_reg <= b_reg;
                    FN_DUP:   r_reg <= a_reg;
                    FN_PRINT: val_reg <= b_reg;
                    FN_PEEK:  val_reg <= (sp_reg == '0) ? 32'd0 : top_reg;
                    default:  r_reg <= r_reg;
                endcase
                // Mod divides the integer parts; the remainder takes the sign of a.
                if (func_reg == FN_MOD)
                begin
                    dneg_reg <= ia16[15];
                    dq_reg   <= {ia_mag, 32'h0000_0000};
                    dden_reg <= {16'h0000, ib_mag};
                end
                else
                begin
                    dneg_reg <= a_reg[31] ^ b_reg[31];
                    dq_reg   <= {(a_reg[31] ? (~a_reg + 32'd1) : a_reg), 16'h0000};
                    dden_reg <= b_reg[31] ? (~b_reg + 32'd1) : b_reg;
                end
                drem_reg <= '0;
            end
            OP_DIVST:
            begin
                if (!trial[32])
                begin
                    drem_reg <= trial;
                    dq_reg <= {dq_reg[46:0], 1'b1};
                end
                else
                begin
                    drem_reg <= {drem_reg[31:0], dq_reg[47]};
                    dq_reg <= {dq_reg[46:0], 1'b0};
                end
            end
            OP_WB:
            begin
                if (func_reg == FN_DIV && !dz_reg)
                    r_reg <= sat48(dneg_reg ? -$signed({1'b0, dq_reg[46:0]}) - 48'sd0
                                            : $signed({1'b0, dq_reg[46:0]}) +
                                              (dq_reg[47] ? 48'sh7fffffffffff : 48'sd0));
                if (func_reg == FN_SWAP) r_reg <= a_reg;
            end
            default: ;
        endcase
    end

    // Value written by the push in this step.
    logic [31:0] push_val;
    logic signed [47:0] dq_s;
    assign dq_s = dneg_reg ? -$signed({1'b0, dq_reg[46:0]}) : $signed({1'b0, dq_reg[46:0]});
    always_comb
    begin
        push_val = r_reg;
        if (func_reg == FN_DIV)
            push_val = dq_reg[47] ? (dneg_reg ? 32'h80000000 : 32'h7fffffff) : sat48(dq_s);
        else if (func_reg == FN_MOD)
            push_val = dneg_reg ? (~rem_q + 32'd1) : rem_q;
    end

    assign push_we = (cmd.op == OP_WB || cmd.op == OP_PUSH2) && sp_reg < DEPTH_C &&
                     !(cmd.op == OP_WB && (func_reg == FN_CLEAR || func_reg == FN_PRINT ||
                       func_reg == FN_PEEK || func_reg == FN_STORE || func_reg > FN_DUP ||
                       dz_reg));

    // Stack memory write and registered read of the next top entry.
    always_ff @(posedge clk)
    begin
        if (push_we)
            stack_mem[sp_reg[AW-1:0]] <= (cmd.op == OP_PUSH2) ? r_reg : push_val;
        top_reg <= stack_mem[rd_ptr[AW-1:0]];
    end

    assign res_value = val_reg;
    assign res_valid = valid_reg;
    assign res_under = under_reg;
    assign res_over = over_reg;
    assign res_dz = dz_reg;

    `ASSERT_IMPL(a_sp_bound, clk, rst_n, 1'b1, sp_reg <= DEPTH_C, "stack pointer past depth")
    `ASSERT_NEXT(a_clear, clk, rst_n, cmd.op == OP_WB && func_reg == FN_CLEAR, sp_reg == '0,
                 "clear left entries")
    `ASSERT_IMPL(a_divcnt, clk, rst_n, cmd.op == OP_DIVST, dcnt_reg != 6'd0,
                 "divider stepped past end")
endmodule

/* design/rpn_ctrl.sv */
// Controller state machine of the RPN calculator.
// Depends on rpn_pkg and assert_macros.svh.
module rpn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rpn_pkg::rpn_cmd_t  cmd,
    input  rpn_pkg::rpn_stat_t stat
);
    import rpn_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POPB = 3'd1;
    localparam logic [2:0] S_POPA = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_PUSH2 = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic pops_b, pops_a, two_push;

    assign pops_b = stat.func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD, FN_PRINT,
                                       FN_SWAP};
    assign pops_a = stat.func inside {FN_ADD, FN_SUB, FN_MUL, FN_SWAP, FN_STORE, FN_DUP};
    assign two_push = stat.func inside {FN_SWAP, FN_DUP};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = OP_START;
                    state_next = S_POPB;
                end
            end
            S_POPB:
            begin
                if (pops_b) cmd.op = OP_POPB;
                state_next = S_POPA;
            end
            S_POPA:
            begin
                // Div and mod pop a only when b is usable.
                if (pops_a || ((stat.func == FN_DIV || stat.func == FN_MOD) && !stat.bzero))
                    cmd.op = OP_POPA;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // Div and mod both run the iterative divider when b is usable.
                cmd.op = OP_EXEC;
                state_next = ((stat.func == FN_DIV || stat.func == FN_MOD) && !stat.bzero) ?
                             S_DIV : S_WB;
            end
            S_DIV:
            begin
                if (stat.div_done) state_next = S_WB;
                else cmd.op = OP_DIVST;
            end
            S_WB:
            begin
                cmd.op = OP_WB;
                state_next = two_push ? S_PUSH2 : S_OUT;
            end
            S_PUSH2:
            begin
                cmd.op = OP_PUSH2;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    `ASSERT_NEXT(a_accept, clk, rst_n, s_tvalid && s_tready, state_reg == S_POPB,
                 "accepted request not started")
    `ASSERT_NEXT(a_deliver, clk, rst_n, m_tvalid && m_tready, state_reg == S_IDLE,
                 "result not released")
    `ASSERT_IMPL(a_excl, clk, rst_n, 1'b1, !(s_tready && m_tvalid), "accept while holding")
endmodule

/* design/rpn_stack_calculator_top.sv */
// Top level of the RPN stack calculator.
// Depends on rpn_pkg, rpn_ctrl and rpn_datapath.
//
// One token enters on the s_axis channel per request and produces exactly
// one result on the m_axis channel. Tokens are processed one at a time: the
// controller walks pop, execute and push steps over the stack memory, whose
// top entry is read through a register. The result request becomes valid
// after the pop, execute and write-back steps, and after a second push for
// swap and dup, which push twice. Div by a nonzero b adds the 48-step
// restoring divider that yields one quotient bit a cycle; mod runs the same
// divider for 16 steps on the integer parts. The result stays in its
// register until taken; the input reports ready again the cycle after the
// result request completes, so no new token is accepted before the last
// result is taken. Reset clears the stack pointer, the variables and the
// controller; the stack contents are undefined until pushed. While the
// receiver stalls, the result holds and no new token is accepted.
//
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // func[3:0], number_value[35:4], var_index[40:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // out_value[31:0], out_valid, underflow,
                                       // overflow, div_zero [35:32]
);
    import rpn_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);

    rpn_cmd_t  cmd;
    rpn_stat_t stat;
    logic [31:0] res_value;
    logic res_valid, res_under, res_over, res_dz;

    rpn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    rpn_datapath #(.STACK_DEPTH(STACK_DEPTH), .SPW(SPW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_func(s_axis_tdata[3:0]), .in_num(s_axis_tdata[35:4]),
        .in_idx(s_axis_tdata[40:36]),
        .res_value(res_value), .res_valid(res_valid), .res_under(res_under),
        .res_over(res_over), .res_dz(res_dz)
    );

    assign m_axis_tdata = {4'h0, res_dz, res_over, res_under, res_valid, res_value};
endmodule

/* test/testbench.sv */
// Testbench for the RPN stack calculator: random and directed tokens, checked
// against a behavioral stack machine. Depends on rpn_pkg and the top level.
`timescale 1ns / 100ps

module testbench;
    import rpn_pkg::*;

    localparam int DEPTH = 128;

    typedef struct packed {
        logic signed [31:0] value;
        logic               valid;
        logic               under;
        logic               over;
        logic               dzero;
    } calc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // func, number_value, var_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // out_value, out_valid, underflow, overflow, div_zero

    // Behavioral copy of the machine state.
    logic signed [31:0] calc_stack [DEPTH];
    int                 calc_depth;
    logic signed [31:0] calc_vars [26];
    bit                 pop_empty, push_full;

    calc_result_t expected_results[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  hold_off = 1'b0;

    rpn_stack_calculator_top #(.STACK_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 clk = ~clk;

    // Abort on a runaway run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] stack_pop();
        if (calc_depth == 0)
        begin
            pop_empty = 1'b1;
            return 0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    function automatic void stack_push(input logic signed [31:0] v);
        if (calc_depth >= DEPTH)
            push_full = 1'b1;
        else
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    function automatic logic signed [63:0] whole_part(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return (w >= 0) ? (w >>> 16) : -((-w) >>> 16);
    endfunction

    // Works out the result of one token and updates the state copy.
    function automatic calc_result_t evaluate_token(input logic [3:0] fn,
            input logic signed [31:0] num, input logic [4:0] idx);
        calc_result_t r;
        logic signed [31:0] a, b;
        logic signed [63:0] p, ia, ib;
        r = '0;
        pop_empty = 1'b0;
        push_full = 1'b0;
        case (fn)
            FN_PUSH: stack_push(num);
            FN_ADD:
            begin
                b = stack_pop(); a = stack_pop();
                stack_push(sat32(64'(a) + 64'(b)));
            end
            FN_SUB:
            begin
                b = stack_pop(); a = stack_pop();
                stack_push(sat32(64'(a) - 64'(b)));
            end
            FN_MUL:
            begin
                b = stack_pop(); a = stack_pop();
                p = 64'(a) * 64'(b);
                stack_push(sat32(p >>> 16));
            end
            FN_DIV:
            begin
                b = stack_pop();
                if (b == 0)
                    r.dzero = 1'b1;
                else
                begin
                    a = stack_pop();
                    stack_push(sat32((64'(a) * 64'sd65536) / 64'(b)));
                end
            end
            FN_MOD:
            begin
                b = stack_pop();
                ib = whole_part(b);
                if (ib == 0)
                    r.dzero = 1'b1;
                else
                begin
                    a = stack_pop();
                    ia = whole_part(a);
                    stack_push(sat32((ia % ib) * 64'sd65536));
                end
            end
            FN_PRINT:
            begin
                r.value = stack_pop();
                r.valid = 1'b1;
            end
            FN_STORE:
            begin
                a = stack_pop();
                if (idx < 26) calc_vars[idx] = a;
            end
            FN_LOAD: stack_push(idx < 26 ? calc_vars[idx] : 32'sd0);
            FN_SWAP:
            begin
                b = stack_pop(); a = stack_pop();
                stack_push(b); stack_push(a);
            end
            FN_PEEK:
            begin
                r.valid = 1'b1;
                if (calc_depth == 0) pop_empty = 1'b1;
                else r.value = calc_stack[calc_depth - 1];
            end
            FN_CLEAR: calc_depth = 0;
            FN_DUP:
            begin
                a = stack_pop();
                stack_push(a); stack_push(a);
            end
            default: ;
        endcase
        r.under = pop_empty;
        r.over = push_full;
        return r;
    endfunction

    // Sends one token after a random gap and records its expected result.
    // Valid stays high after acceptance until the next call drives it.
    task automatic send_token(input logic [3:0] fn, input logic signed [31:0] num,
            input logic [4:0] idx);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {7'b0, idx, num, fn};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_results.push_back(evaluate_token(fn, num, idx));
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
                if (wait_cycles != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge clk);
                while (!m_axis_tvalid) @(posedge clk);
            end
        end
    end

    // Checks every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        calc_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                   m_axis_tdata[34], m_axis_tdata[35]};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected value %h valid %b under %b over %b dz %b,",
                        $realtime, want.value, want.valid, want.under, want.over,
                        want.dzero);
                    $display("%0t: actual   value %h valid %b under %b over %b dz %b",
                        $realtime, got.value, got.valid, got.under, got.over,
                        got.dzero);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 20) << 16) - 32'sd655360;
            3: return 0;
            default: return $urandom();
        endcase
    endfunction

    // Extremes and special cases on a nearly empty stack.
    task automatic test_directed();
        send_token(FN_PRINT, 0, 0);
        send_token(FN_PEEK, 0, 0);
        send_token(FN_DUP, 0, 0);
        send_token(FN_SWAP, 0, 0);
        send_token(FN_CLEAR, 0, 0);
        send_token(FN_PUSH, 32'sh7fffffff, 0);
        send_token(FN_PUSH, 32'sh7fffffff, 0);
        send_token(FN_ADD, 0, 0);
        send_token(FN_PUSH, 32'sh80000000, 0);
        send_token(FN_MUL, 0, 0);
        send_token(FN_PUSH, 0, 0);
        send_token(FN_DIV, 0, 0);
        send_token(FN_PUSH, 32'sh00008000, 0);
        send_token(FN_MOD, 0, 0);
        send_token(FN_PUSH, 32'shffff0000, 0);
        send_token(FN_DIV, 0, 0);
        send_token(FN_STORE, 0, 25);
        send_token(FN_LOAD, 0, 25);
        send_token(FN_STORE, 0, 31);
        send_token(FN_LOAD, 0, 31);
        send_token(FN_SUB, 0, 0);
        send_token(4'd15, 32'shffffffff, 5'd31);
        send_token(FN_PRINT, 0, 0);
    endtask

    // Fill past the top so the overflow path and dup on a full stack are hit.
    task automatic test_full_stack();
        send_token(FN_CLEAR, 0, 0);
        for (int i = 0; i < DEPTH + 2; i++) send_token(FN_PUSH, random_value(), 0);
        send_token(FN_DUP, 0, 0);
        send_token(FN_LOAD, 0, 3);
        send_token(FN_PEEK, 0, 0);
        send_token(FN_CLEAR, 0, 0);
    endtask

    // Receiver holds off while tokens keep coming, so the block stalls.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_token(FN_PUSH, random_value(), 0);
            end
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // Mostly operand-balanced random tokens, some noise.
    task automatic test_random();
        logic [3:0] fn;
        for (int i = 0; i < 560; i++)
        begin
            if (calc_depth < 2 && $urandom_range(0, 3) != 0)
                fn = ($urandom_range(0, 1) != 0) ? FN_PUSH : FN_LOAD;
            else
                fn = 4'($urandom_range(0, 15));
            send_token(fn, random_value(), 5'($urandom_range(0, 31)));
        end
    endtask

    initial
    begin
        int drain;
        calc_depth = 0;
        foreach (calc_vars[i]) calc_vars[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_stack();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
